// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker module of this project.
// Needs a signal named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/cfws_pkg.sv
// Package for the card queue with search: sizes, opcode and status codes,
// and the control bundle that drives the row of storage cells. No dependencies.
package cfws_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int RANK_W   = 4;
  localparam int SUIT_W   = 2;
  localparam int WORD_W   = RANK_W + SUIT_W;
  localparam int OP_W     = 3;
  localparam int POS_W    = 6;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 7;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE  = 3'd0,
    OP_DEQUEUE  = 3'd1,
    OP_CONTAINS = 3'd2,
    OP_PEEK     = 3'd3,
    OP_CLEAR    = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic              step;
    logic              enq;
    logic              deq;
    logic [WORD_W-1:0] word;
    logic [IDX_W-1:0]  sel;
    logic [CNT_W-1:0]  count;
  } cell_ctrl_t;

endpackage

// File: rtl/core/cfws_cell.sv
// One storage cell of the queue: holds the entry at its position from the
// front, shifts forward on a dequeue and flags a match or a peek. Uses cfws_pkg.
module cfws_cell (
  input  logic                      clk,
  input  cfws_pkg::cell_ctrl_t      ctrl,
  input  logic [cfws_pkg::IDX_W-1:0]  cell_idx,
  input  logic [cfws_pkg::WORD_W-1:0] nbr_data,
  output logic [cfws_pkg::WORD_W-1:0] data,
  output logic                      hit,
  output logic [cfws_pkg::WORD_W-1:0] peek_data
);
  import cfws_pkg::*;

  logic [WORD_W-1:0] data_r;
  logic              hit_r;
  logic [WORD_W-1:0] peek_r;
  logic              valid;

  assign valid = (CNT_W'(cell_idx) < ctrl.count);

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      hit_r  <= valid && (data_r == ctrl.word);
      peek_r <= (cell_idx == ctrl.sel) ? data_r : '0;
      if (ctrl.deq) begin
        data_r <= nbr_data;
      end else if (ctrl.enq && (CNT_W'(cell_idx) == ctrl.count)) begin
        data_r <= ctrl.word;
      end
    end
  end

  assign data      = data_r;
  assign hit       = hit_r;
  assign peek_data = peek_r;

endmodule

// File: rtl/core/cfws_chain.sv
// Row of storage cells, each passing its entry to the cell in front of it,
// with the OR reduction of the match flags and peek words. Uses cfws_pkg, cfws_cell.
module cfws_chain (
  input  logic                        clk,
  input  cfws_pkg::cell_ctrl_t        ctrl,
  output logic                        any_hit,
  output logic [cfws_pkg::WORD_W-1:0] sel_data
);
  import cfws_pkg::*;

  logic [WORD_W-1:0] data_vec [CAPACITY];
  logic [WORD_W-1:0] peek_vec [CAPACITY];
  logic [CAPACITY-1:0] hit_vec;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_W-1:0] nbr;
    if (g == CAPACITY - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = data_vec[g+1];
    end
    cfws_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .cell_idx  (IDX_W'(g)),
      .nbr_data  (nbr),
      .data      (data_vec[g]),
      .hit       (hit_vec[g]),
      .peek_data (peek_vec[g])
    );
  end

  assign any_hit = |hit_vec;

  always_comb begin
    sel_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_data = sel_data | peek_vec[i];
    end
  end

endmodule

// File: rtl/core/card_fifo_with_search_top.sv
// Card queue with search: a request is taken when start is high and busy low.
// Its result shows on out_valid, after the ph1_r and ph2_r registers, for one cycle.
// A request may be taken every second cycle; the row of cells compares, shifts
// and captures while ph1_r is high, and the reduction is shown in the next cycle.
// Synchronous active-low reset empties the queue; cell contents are not cleared.
module card_fifo_with_search_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [cfws_pkg::OP_W-1:0]    in_opcode,
  input  logic [cfws_pkg::RANK_W-1:0]  in_card_rank,
  input  logic [cfws_pkg::SUIT_W-1:0]  in_card_suit,
  input  logic [cfws_pkg::POS_W-1:0]   in_position,
  output logic                         out_valid,
  output logic [cfws_pkg::RANK_W-1:0]  out_rank,
  output logic [cfws_pkg::SUIT_W-1:0]  out_suit,
  output logic                         out_found,
  output logic [cfws_pkg::STAT_W-1:0]  out_status,
  output logic [cfws_pkg::COUNT_W-1:0] out_count
);
  import cfws_pkg::*;

  logic              ph1_r, ph1_nxt;
  logic              ph2_r, ph2_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  op_t               op_r;
  logic [WORD_W-1:0] word_r;
  logic [POS_W-1:0]  pos_r;
  op_t               op2_r;
  status_t           st_r, st_nxt;

  logic              accept;
  logic              full, empty, enq_ok, deq_ok;
  logic [CNT_W-1:0]  last_idx;
  logic [CMP_W-1:0]  pos_ext, last_ext, pos_clamp;
  cell_ctrl_t        ctrl;
  logic              any_hit;
  logic [WORD_W-1:0] sel_data;
  logic              show_data;

  assign accept  = start && !busy;
  assign busy    = ph1_r;
  assign ph1_nxt = accept;
  assign ph2_nxt = ph1_r;

  assign full   = (count_r == CNT_W'(CAPACITY));
  assign empty  = (count_r == '0);
  assign enq_ok = (op_r == OP_ENQUEUE) && !full;
  assign deq_ok = (op_r == OP_DEQUEUE) && !empty;

  assign last_idx  = count_r - CNT_W'(1);
  assign pos_ext   = CMP_W'(pos_r);
  assign last_ext  = CMP_W'(last_idx);
  assign pos_clamp = (pos_ext > last_ext) ? last_ext : pos_ext;

  always_comb begin
    ctrl.step  = ph1_r;
    ctrl.enq   = enq_ok;
    ctrl.deq   = deq_ok;
    ctrl.word  = word_r;
    ctrl.sel   = (op_r == OP_PEEK) ? IDX_W'(pos_clamp) : '0;
    ctrl.count = count_r;
  end

  always_comb begin
    count_nxt = count_r;
    if (op_r == OP_CLEAR) begin
      count_nxt = '0;
    end else if (enq_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (deq_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    st_nxt = ST_OK;
    unique case (op_r) inside
      OP_ENQUEUE: if (full) st_nxt = ST_FULL;
      OP_DEQUEUE, OP_PEEK: if (empty) st_nxt = ST_EMPTY;
      default: st_nxt = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph1_r   <= 1'b0;
      ph2_r   <= 1'b0;
      count_r <= '0;
    end else begin
      ph1_r <= ph1_nxt;
      ph2_r <= ph2_nxt;
      if (ph1_r) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= op_t'(in_opcode);
      word_r <= {in_card_rank, in_card_suit};
      pos_r  <= in_position;
    end
    if (ph1_r) begin
      op2_r <= op_r;
      st_r  <= st_nxt;
    end
  end

  cfws_chain u_chain (
    .clk      (clk),
    .ctrl     (ctrl),
    .any_hit  (any_hit),
    .sel_data (sel_data)
  );

  assign show_data  = ((op2_r == OP_DEQUEUE) || (op2_r == OP_PEEK)) && (st_r == ST_OK);
  assign out_valid  = ph2_r;
  assign out_rank   = show_data ? sel_data[WORD_W-1:SUIT_W] : '0;
  assign out_suit   = show_data ? sel_data[SUIT_W-1:0] : '0;
  assign out_found  = (op2_r == OP_CONTAINS) && any_hit;
  assign out_status = st_r;
  assign out_count  = COUNT_W'(count_r);

endmodule

// File: rtl/core/cfws_checker.sv
// Port-level checker for the card queue with search, bound to the top level.
// Uses cfws_pkg and the macros of assert_macros.svh.
`include "assert_macros.svh"

module cfws_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic                         out_found,
  input logic [cfws_pkg::STAT_W-1:0]  out_status,
  input logic [cfws_pkg::COUNT_W-1:0] out_count
);
  import cfws_pkg::*;

  `ASSERT_CLK(a_busy_after_req, (start && !busy) |=> busy, "busy not raised after a request")
  `ASSERT_CLK(a_result_follows, (start && !busy) |-> ##2 out_valid, "result missing after a request")
  `ASSERT_CLK(a_single_strobe, out_valid |=> !out_valid, "result strobe held for two cycles")
  `ASSERT_CLK(a_empty_count, (out_valid && out_status == ST_EMPTY) |-> (out_count == '0),
              "empty status with entries held")
  `ASSERT_CLK(a_found_count, (out_valid && out_found) |-> (out_count != '0),
              "match reported on an empty queue")

endmodule

bind card_fifo_with_search_top cfws_checker u_cfws_checker (.*);
